>>> hw/rtl/steepest_neighbor_pointer_map_assert.svh
// Assertion macros for the steepest-neighbour pointer map.
// Included by the RTL files that carry concurrent checks; needs aclk and aresetn in scope.
`ifndef STEEPEST_NEIGHBOR_POINTER_MAP_ASSERT_SVH
`define STEEPEST_NEIGHBOR_POINTER_MAP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SNPM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("steepest_neighbor_pointer_map: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SNPM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("steepest_neighbor_pointer_map: next-cycle check failed");

`endif

>>> hw/rtl/snpm_pkg.sv
// Shared types and constants of the steepest-neighbour pointer map.
// No dependencies; imported by steepest_neighbor_pointer_map.
package snpm_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 11;
    localparam int COUNT_BITS     = 21;
    localparam int PIXEL_BITS     = 20;
    localparam int MAP_BITS       = 21;
    localparam int TAP_BITS       = 4;
    localparam int WIN_TAPS       = 9;
    localparam int CENTRE_TAP     = 4;

    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int MAX_HEIGHT        = 1024;

    localparam logic [CFG_DATA_BITS-1:0] FRAME_WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_DATA_BITS-1:0] FRAME_HEIGHT_RESET = 11'd1024;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

    localparam cfg_index_t REG_FRAME_WIDTH  = 2'd0;
    localparam cfg_index_t REG_FRAME_HEIGHT = 2'd1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef struct packed {
        logic                          kind;
        logic signed [SAMPLE_BITS-1:0] sample;
    } in_t;

    typedef struct packed {
        logic [MAP_BITS-1:0]   map_index;
        logic [PIXEL_BITS-1:0] pixel_index;
        logic                  last_pixel;
    } out_t;

    // Per-request control that travels alongside the window through the pipeline.
    typedef struct packed {
        logic                  emit;
        logic                  in_range;
        logic                  last;
        logic [PIXEL_BITS-1:0] pixel_index;
    } meta_t;

endpackage

>>> hw/rtl/steepest_neighbor_pointer_map.sv
// Steepest-neighbour pointer map: top level, with line store, 3x3 window and compare pipeline.
// Depends on snpm_pkg and steepest_neighbor_pointer_map_assert.svh.
`include "steepest_neighbor_pointer_map_assert.svh"

// The block takes a frame in raster order, one request per cycle while s_ready is high, and
// for each pixel returns the 1-based raster index of the largest sample in its 3x3 block (ties
// keep the centre or the earlier neighbour, neighbours wrap across row ends). It sustains one
// request per clock unless the output stalls or a register write holds the input off: the line
// store is a single memory with one write and two read ports, all used once per request, and
// the nine-tap compare is a pipeline stage of its own. A request is registered into stage 1 on
// accept and then passes the window, compare and output registers. Results lag the input by
// frame_width+1 requests, so the first frame_width+1 requests of a frame give no result, and
// flushes (kind = 1) push the frame's tail out. Pixels with index under frame_width+1 or over
// N-frame_width-2 (N pixels per frame) get map_index 0. The line store holds 2*MAX_WIDTH+2
// samples and needs no clearing after reset, since every entry a real result reads was written
// earlier in the same frame. Writing either register restarts the frame; configuration is to
// be written while the block is idle. The frame size derived from them is registered, so the
// input is held off during a register write, for the cycle after it and the first after reset.
module steepest_neighbor_pointer_map #(
    parameter int MAX_WIDTH = snpm_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // pixel requests
    input  logic                   s_valid,
    output logic                   s_ready,
    input  snpm_pkg::in_t          s_data,
    // results
    output logic                   m_valid,
    input  logic                   m_ready,
    output snpm_pkg::out_t         m_data,
    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  snpm_pkg::cfg_index_t   cfg_index,
    input  snpm_pkg::cfg_data_t    cfg_data
);
    import snpm_pkg::*;

    localparam int DEPTH     = 2 * MAX_WIDTH + 2;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int AW        = ADDR_BITS + 1;

    // ------------------------------------------------------------------
    // Configuration registers and the frame geometry derived from them.
    // ------------------------------------------------------------------
    cfg_data_t              frame_width_reg;
    cfg_data_t              frame_height_reg;
    cfg_data_t              frame_w_reg;   // clamped width
    logic [COUNT_BITS-1:0]  frame_n_reg;   // pixels per frame
    cfg_data_t              w_clamp;
    cfg_data_t              h_clamp;
    logic                   cfg_hit;
    logic                   geom_wait_reg; // derived geometry not yet settled

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && ((cfg_index == REG_FRAME_WIDTH) ||
                                     (cfg_index == REG_FRAME_HEIGHT));

    always_comb begin
        priority if (frame_width_reg == '0) begin
            w_clamp = cfg_data_t'(1);
        end else if (32'(frame_width_reg) > MAX_WIDTH) begin
            w_clamp = cfg_data_t'(MAX_WIDTH);
        end else begin
            w_clamp = frame_width_reg;
        end
        priority if (frame_height_reg == '0) begin
            h_clamp = cfg_data_t'(1);
        end else if (32'(frame_height_reg) > MAX_HEIGHT) begin
            h_clamp = cfg_data_t'(MAX_HEIGHT);
        end else begin
            h_clamp = frame_height_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_FRAME_WIDTH) begin
                frame_width_reg <= cfg_data;
            end
            if (cfg_index == REG_FRAME_HEIGHT) begin
                frame_height_reg <= cfg_data;
            end
        end
    end

    // Geometry is re-registered every cycle; a small multiply, off the request path.
    always_ff @(posedge aclk) begin
        frame_w_reg <= w_clamp;
        frame_n_reg <= COUNT_BITS'(w_clamp) * COUNT_BITS'(h_clamp);
    end

    // The registered geometry lags a register write, and reset;
    // requests wait for it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geom_wait_reg <= 1'b1;
        end else begin
            geom_wait_reg <= cfg_hit;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake. Each stage moves on when the one after it is
    // empty or moving, so bubbles collapse and the input keeps flowing
    // until the stages fill behind a result held in the output register.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic m_valid_reg,  m_valid_next;
    logic s_acc, s1_adv, s2_adv, s3_adv;

    assign s3_adv  = s3_valid_reg && (!m_valid_reg || m_ready);
    assign s2_adv  = s2_valid_reg && (!s3_valid_reg || s3_adv);
    assign s1_adv  = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign s_ready = (!s1_valid_reg || s1_adv) && !geom_wait_reg && !cfg_hit;
    assign s_acc   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Stage 0: position in the frame and what this request produces.
    // The request at position c completes pixel c-W-1, whose newest
    // window column is (c-2W, c-W, c).
    // ------------------------------------------------------------------
    logic [COUNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [ADDR_BITS-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [ADDR_BITS-1:0]       rd1_addr, rd2_addr;
    logic [AW-1:0]              rd1_diff, rd2_diff;
    logic [COUNT_BITS-1:0]      cw;
    logic                       s0_before_end;
    logic                       s0_last;
    logic signed [SAMPLE_BITS-1:0] s0_val;
    meta_t                      s0_meta;

    assign cw            = COUNT_BITS'(frame_w_reg);
    assign s0_before_end = cnt_reg < frame_n_reg;
    assign s0_last       = ({1'b0, cnt_reg} ==
                            ({1'b0, frame_n_reg} + (COUNT_BITS + 1)'(frame_w_reg)));
    // Flushes, and samples arriving past the frame end, fill the slot with zero.
    assign s0_val = ((s_data.kind == KIND_SAMPLE) && s0_before_end) ? s_data.sample : '0;

    always_comb begin
        s0_meta.emit        = cnt_reg >= (cw + COUNT_BITS'(1));
        s0_meta.in_range    = (cnt_reg >= ((cw << 1) + COUNT_BITS'(2))) && s0_before_end;
        s0_meta.last        = s0_last;
        s0_meta.pixel_index = PIXEL_BITS'(cnt_reg - cw - COUNT_BITS'(1));
    end

    // Read addresses one and two rows back, modulo the store depth.
    always_comb begin
        rd1_diff = {1'b0, wr_ptr_reg} - AW'(frame_w_reg);
        rd2_diff = {1'b0, wr_ptr_reg} - (AW'(frame_w_reg) << 1);
        if (rd1_diff[AW-1]) begin
            rd1_diff = rd1_diff + AW'(DEPTH);
        end
        if (rd2_diff[AW-1]) begin
            rd2_diff = rd2_diff + AW'(DEPTH);
        end
        rd1_addr = rd1_diff[ADDR_BITS-1:0];
        rd2_addr = rd2_diff[ADDR_BITS-1:0];
    end

    always_comb begin
        cnt_next    = cnt_reg;
        wr_ptr_next = wr_ptr_reg;
        if (cfg_hit) begin
            cnt_next    = '0;
            wr_ptr_next = '0;
        end else if (s_acc) begin
            if (s0_last) begin
                cnt_next    = '0;
                wr_ptr_next = '0;
            end else begin
                cnt_next = cnt_reg + COUNT_BITS'(1);
                if (32'(wr_ptr_reg) == DEPTH - 1) begin
                    wr_ptr_next = '0;
                end else begin
                    wr_ptr_next = wr_ptr_reg + ADDR_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            wr_ptr_reg <= '0;
        end else begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store. The read addresses trail the write address by W and 2W
    // entries, both below the depth, so a read never meets the entry
    // written in the same cycle and no forwarding is needed.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] store_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd1_reg, rd2_reg;

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            store_mem[wr_ptr_reg] <= s0_val;
            rd1_reg               <= store_mem[rd1_addr];
            rd2_reg               <= store_mem[rd2_addr];
        end
    end

    // Stage 1: new sample and its metadata, alongside the memory read data.
    logic signed [SAMPLE_BITS-1:0] s1_val_reg;
    meta_t                         s1_meta_reg;

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_val_reg  <= s0_val;
            s1_meta_reg <= s0_meta;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the 3x3 window, taps numbered row by row with x fastest.
    // Every request shifts it one column, result or not.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] win_reg [WIN_TAPS];
    meta_t                         s2_meta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WIN_TAPS; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_adv) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= rd2_reg;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= rd1_reg;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= s1_val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_meta_reg <= s1_meta_reg;
        end
    end

    // Stage 3: winning tap. Start from the centre; only a strictly larger
    // sample takes over, visiting taps in raster order.
    logic [TAP_BITS-1:0]           best_k;
    logic signed [SAMPLE_BITS-1:0] best_v;
    logic [TAP_BITS-1:0]           s3_k_reg;
    meta_t                         s3_meta_reg;

    always_comb begin
        best_k = TAP_BITS'(CENTRE_TAP);
        best_v = win_reg[CENTRE_TAP];
        for (int k = 0; k < WIN_TAPS; k++) begin
            if (win_reg[k] > best_v) begin
                best_v = win_reg[k];
                best_k = TAP_BITS'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            s3_k_reg    <= best_k;
            s3_meta_reg <= s2_meta_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: turn the tap into a linear offset from the pixel,
    // dx + dy*W, and add the unit offset for 1-based indexing.
    // ------------------------------------------------------------------
    logic [MAP_BITS-1:0] map_base, map_off, map_w;
    out_t                m_data_reg;
    out_t                m_data_next;

    always_comb begin
        map_base = MAP_BITS'(s3_meta_reg.pixel_index) + MAP_BITS'(1);
        map_w    = MAP_BITS'(frame_w_reg);
        unique case (s3_k_reg)
            4'd0:    map_off = '0 - map_w - MAP_BITS'(1);
            4'd1:    map_off = '0 - map_w;
            4'd2:    map_off = MAP_BITS'(1) - map_w;
            4'd3:    map_off = '0 - MAP_BITS'(1);
            4'd4:    map_off = '0;
            4'd5:    map_off = MAP_BITS'(1);
            4'd6:    map_off = map_w - MAP_BITS'(1);
            4'd7:    map_off = map_w;
            4'd8:    map_off = map_w + MAP_BITS'(1);
            default: map_off = '0;
        endcase
        m_data_next.map_index   = s3_meta_reg.in_range ? (map_base + map_off) : '0;
        m_data_next.pixel_index = s3_meta_reg.pixel_index;
        m_data_next.last_pixel  = s3_meta_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (s3_adv) begin
            m_data_reg <= m_data_next;
        end
    end

    always_comb begin
        s1_valid_next = s_acc || (s1_valid_reg && !s1_adv);
        s2_valid_next = s1_adv || (s2_valid_reg && !s2_adv);
        s3_valid_next = s2_adv || (s3_valid_reg && !s3_adv);
        if (s3_adv) begin
            // Requests inside the lag pass through but leave no result.
            m_valid_next = s3_meta_reg.emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Checks on the design's own logic.
    // ------------------------------------------------------------------
    `SNPM_ASSERT_NXT(a_frame_restart, s_acc && s0_last, (cnt_reg == '0) && (wr_ptr_reg == '0))
    `SNPM_ASSERT_IMP(a_no_overwrite, m_valid_reg && !m_ready, !s3_adv)
    `SNPM_ASSERT_IMP(a_no_rw_clash, s_acc, (rd1_addr != wr_ptr_reg) && (rd2_addr != wr_ptr_reg))
    `SNPM_ASSERT_IMP(a_range_emits, s3_valid_reg && s3_meta_reg.in_range, s3_meta_reg.emit)
    `SNPM_ASSERT_NXT(a_accept_fills, s_acc, s1_valid_reg)

endmodule
